### sv/amp_pkg.sv
// Shared types and constants for the envelope-modulated auto-pan core.
package amp_pkg;

   localparam int MUL_A_BITS = 34;
   localparam int MUL_B_BITS = 19;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

   typedef struct packed {
      logic [30:0] base_increment;
      logic [15:0] wave_shape;
      logic [15:0] pan_depth;
      logic [15:0] env_speed_mod;
      logic [15:0] env_depth_mod;
      logic [15:0] attack_coef;
      logic [15:0] release_coef;
   } cfg_type;

   typedef enum logic [2:0] {
      REG_BASE_INC   = 3'd0,
      REG_WAVE_SHAPE = 3'd1,
      REG_PAN_DEPTH  = 3'd2,
      REG_SPEED_MOD  = 3'd3,
      REG_DEPTH_MOD  = 3'd4,
      REG_ATTACK     = 3'd5,
      REG_RELEASE    = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      BAND_TRI,
      BAND_SKEW,
      BAND_SQR
   } band_type;

   typedef enum logic [5:0] {
      S_IDLE, S_LEV, S_LVL, S_ENV, S_SPD, S_INC, S_PHS, S_DEP, S_DP2, S_DP3,
      S_DIV0, S_DIV1, S_DIV2, S_WT, S_SK1, S_SK2, S_WB, S_WSV, S_MIXA, S_MIXC,
      S_SC0, S_SC1, S_SC2, S_SC3, S_SC4, S_SC5, S_SC6,
      S_PAN, S_PAN1, S_PAN2, S_PAN3, S_PAN4, S_PAN5,
      S_SIN0, S_SIN1, S_SIN2, S_SIN3, S_SIN4, S_OUT
   } state_type;

   localparam logic [16:0] ONE_Q16   = 17'd65536;
   localparam logic [16:0] MIX_HALF  = 17'd32768;
   localparam logic [16:0] DRY_LIMIT = 17'd656;
   localparam logic [15:0] WAVE_T1   = 16'd19661;
   localparam logic [15:0] WAVE_T2   = 16'd45875;
   localparam logic [15:0] BAND_LOW  = 16'd19661;
   localparam logic [15:0] BAND_MID  = 16'd26214;
   localparam logic [17:0] RECIP_LOW = 18'd218451;
   localparam logic [17:0] RECIP_MID = 18'd163842;
   localparam logic [15:0] SKEW_GAIN = 16'd19661;

   localparam logic [17:0] SIN_A = 18'd102944;
   localparam logic [17:0] SIN_B = 18'd42047;
   localparam logic [17:0] SIN_C = 18'd4640;

   localparam logic [17:0] CLIP_ONE = 18'd131072;
   localparam logic [17:0] CLIP_A   = 18'd43691;
   localparam logic [17:0] CLIP_B   = 18'd17476;
   localparam logic [17:0] CLIP_C   = 18'd7074;

   localparam logic [31:0] HALF_CYCLE    = 32'h8000_0000;
   localparam logic [31:0] QUARTER_CYCLE = 32'h4000_0000;

endpackage

### sv/amp_mul.sv
// Shared signed multiplier with registered product.
module amp_mul (
   input  logic                                   clock,
   input  logic signed [amp_pkg::MUL_A_BITS-1:0]  mul_a,
   input  logic signed [amp_pkg::MUL_B_BITS-1:0]  mul_b,
   output logic signed [amp_pkg::PROD_BITS-1:0]   prod_ff
);

   logic signed [amp_pkg::PROD_BITS-1:0] prod_in;

   assign prod_in = amp_pkg::PROD_BITS'(mul_a) * amp_pkg::PROD_BITS'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

### sv/amp_seq.sv
// Sequencer and datapath registers: envelope, LFO, waveform, pan gains.
module amp_seq #(
   parameter int SAMPLE_BITS     = 24,
   parameter int TABLE_ADDR_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  amp_pkg::cfg_type                      cfg,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic signed [SAMPLE_BITS-1:0]         in_left,
   input  logic signed [SAMPLE_BITS-1:0]         in_right,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic signed [SAMPLE_BITS-1:0]         out_left,
   output logic signed [SAMPLE_BITS-1:0]         out_right,
   output logic signed [amp_pkg::MUL_A_BITS-1:0] mul_a,
   output logic signed [amp_pkg::MUL_B_BITS-1:0] mul_b,
   input  logic signed [amp_pkg::PROD_BITS-1:0]  prod
);

   localparam int SB  = SAMPLE_BITS;
   localparam int AW  = amp_pkg::MUL_A_BITS;
   localparam int BW  = amp_pkg::MUL_B_BITS;
   localparam int PW  = amp_pkg::PROD_BITS;
   localparam int TAB = TABLE_ADDR_BITS;
   localparam int QB  = TAB - 2;
   localparam logic [SB+1:0] FULL_LEVEL = (SB+2)'(1) << (SB - 1);
   localparam logic [QB:0]   QUARTER_N  = (QB+1)'(1) << QB;

   amp_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   amp_pkg::band_type  band_ff, band_in;

   logic signed [SB-1:0] l_ff, l_in, r_ff, r_in;
   logic [SB-1:0]        level_ff, level_in;
   logic [16:0]          env_ff, env_in;
   logic [31:0]          phase_ff, phase_in;
   logic [16:0]          depth_ff, depth_in;
   logic [14:0]          num_ff, num_in;
   logic [16:0]          t_ff, t_in;
   logic [31:0]          sph_ff, sph_in;
   logic [16:0]          x_ff, x_in;
   logic [16:0]          x2_ff, x2_in;
   logic                 neg_ff, neg_in;
   logic signed [17:0]   sin_ff, sin_in;
   logic signed [17:0]   g_ff, g_in;
   logic signed [18:0]   lfo_ff, lfo_in;
   logic signed [SB-1:0] ol_ff, ol_in, or_ff, or_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0] rsp_l_ff, rsp_l_in, rsp_r_ff, rsp_r_in;

   logic signed [PW-1:0] p16;
   logic                 out_free;

   // shared intermediate values
   logic signed [SB:0]   l_ext, absl, diff;
   logic [15:0]          coef;
   logic signed [SB+1:0] lvl_sum;
   logic [SB+1:0]        lv4, lv4c;
   logic [SB+17:0]       env_w;
   logic signed [17:0]   env_c, dfac;
   logic [16:0]          dp;
   logic [31:0]          rem;
   logic [15:0]          div_d;
   logic [17:0]          div_r;
   logic signed [32:0]   phc;
   logic [32:0]          tri_d;
   logic signed [19:0]   tri_v, tgt, sc;
   logic [TAB-1:0]       idx;
   logic [QB:0]          kq;
   logic [17:0]          yv, hv;
   logic [16:0]          mag;
   logic signed [18:0]   pa;

   assign p16      = prod >>> 16;
   assign out_free = !rsp_valid_ff || out_ready;
   assign in_ready = (state_ff == amp_pkg::S_IDLE);
   assign out_valid = rsp_valid_ff;
   assign out_left  = rsp_l_ff;
   assign out_right = rsp_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= amp_pkg::S_IDLE;
         ret_ff       <= amp_pkg::S_IDLE;
         level_ff     <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         level_ff     <= level_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      band_ff  <= band_in;
      l_ff     <= l_in;
      r_ff     <= r_in;
      env_ff   <= env_in;
      depth_ff <= depth_in;
      num_ff   <= num_in;
      t_ff     <= t_in;
      sph_ff   <= sph_in;
      x_ff     <= x_in;
      x2_ff    <= x2_in;
      neg_ff   <= neg_in;
      sin_ff   <= sin_in;
      g_ff     <= g_in;
      lfo_ff   <= lfo_in;
      ol_ff    <= ol_in;
      or_ff    <= or_in;
      rsp_l_ff <= rsp_l_in;
      rsp_r_ff <= rsp_r_in;
   end

   // helpers used by several states
   always_comb begin
      l_ext   = (SB+1)'(l_ff);
      absl    = (l_ext < 0) ? -l_ext : l_ext;
      diff    = absl - $signed({1'b0, level_ff});
      coef    = (absl > $signed({1'b0, level_ff})) ? cfg.attack_coef : cfg.release_coef;
      lvl_sum = (SB+2)'($signed({1'b0, level_ff})) + (SB+2)'(p16);
      lv4     = {level_ff, 2'b00};
      lv4c    = (lv4 > FULL_LEVEL) ? FULL_LEVEL : lv4;
      env_w   = {lv4c, 16'b0} >> (SB - 1);
      env_c   = $signed({1'b0, env_ff}) - $signed({1'b0, amp_pkg::MIX_HALF});
      dfac    = $signed({1'b0, amp_pkg::ONE_Q16}) + 18'(p16);
      dp      = prod[32:16];
      div_d   = (band_ff == amp_pkg::BAND_SKEW) ? amp_pkg::BAND_MID : amp_pkg::BAND_LOW;
      div_r   = (band_ff == amp_pkg::BAND_SKEW) ? amp_pkg::RECIP_MID : amp_pkg::RECIP_LOW;
      rem     = {1'b0, num_ff, 16'b0} - prod[31:0];
      phc     = $signed({1'b0, phase_ff}) - $signed({1'b0, amp_pkg::HALF_CYCLE});
      tri_d   = phase_ff[31] ? (33'h1_0000_0000 - {1'b0, phase_ff}) : {1'b0, phase_ff};
      tri_v   = $signed({1'b0, tri_d[32:14]}) - $signed({3'b0, amp_pkg::ONE_Q16});
      tgt     = (sin_ff >= 0) ? $signed({3'b0, amp_pkg::ONE_Q16})
                              : -$signed({3'b0, amp_pkg::ONE_Q16});
      idx     = sph_ff[31 -: TAB];
      kq      = idx[QB] ? (QUARTER_N - {1'b0, idx[QB-1:0]}) : {1'b0, idx[QB-1:0]};
      yv      = prod[33:16];
      hv      = prod[34:17];
      mag     = (lfo_ff < 0) ? 17'(-lfo_ff) : 17'(lfo_ff);
      sc      = neg_ff ? -$signed({3'b0, prod[33:17]}) : $signed({3'b0, prod[33:17]});
      pa      = 19'(p16) + $signed({2'b0, amp_pkg::ONE_Q16});
   end

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         amp_pkg::S_IDLE: if (in_valid) state_in = amp_pkg::S_LEV;
         amp_pkg::S_LEV:  state_in = amp_pkg::S_LVL;
         amp_pkg::S_LVL:  state_in = amp_pkg::S_ENV;
         amp_pkg::S_ENV:  state_in = amp_pkg::S_SPD;
         amp_pkg::S_SPD:  state_in = amp_pkg::S_INC;
         amp_pkg::S_INC:  state_in = amp_pkg::S_PHS;
         amp_pkg::S_PHS:  state_in = amp_pkg::S_DEP;
         amp_pkg::S_DEP:  state_in = amp_pkg::S_DP2;
         amp_pkg::S_DP2:  state_in = amp_pkg::S_DP3;
         amp_pkg::S_DP3: begin
            state_in = amp_pkg::S_DIV0;
            ret_in   = amp_pkg::S_WT;
         end
         amp_pkg::S_DIV0: state_in = amp_pkg::S_DIV1;
         amp_pkg::S_DIV1: state_in = amp_pkg::S_DIV2;
         amp_pkg::S_DIV2: state_in = ret_ff;
         amp_pkg::S_WT: begin
            if (band_ff == amp_pkg::BAND_SKEW) begin
               state_in = amp_pkg::S_SK1;
            end else begin
               state_in = amp_pkg::S_SIN0;
               ret_in   = amp_pkg::S_WSV;
            end
         end
         amp_pkg::S_SK1: state_in = amp_pkg::S_SK2;
         amp_pkg::S_SK2: begin
            state_in = amp_pkg::S_SIN0;
            ret_in   = amp_pkg::S_WB;
         end
         amp_pkg::S_WB:  state_in = amp_pkg::S_PAN;
         amp_pkg::S_WSV: state_in = (band_ff == amp_pkg::BAND_TRI) ? amp_pkg::S_MIXA
                                                                   : amp_pkg::S_MIXC;
         amp_pkg::S_MIXA: state_in = amp_pkg::S_PAN;
         amp_pkg::S_MIXC: state_in = (t_ff > amp_pkg::MIX_HALF) ? amp_pkg::S_SC0
                                                                : amp_pkg::S_PAN;
         amp_pkg::S_SC0: state_in = amp_pkg::S_SC1;
         amp_pkg::S_SC1: state_in = amp_pkg::S_SC2;
         amp_pkg::S_SC2: state_in = amp_pkg::S_SC3;
         amp_pkg::S_SC3: state_in = amp_pkg::S_SC4;
         amp_pkg::S_SC4: state_in = amp_pkg::S_SC5;
         amp_pkg::S_SC5: state_in = amp_pkg::S_SC6;
         amp_pkg::S_SC6: state_in = amp_pkg::S_PAN;
         amp_pkg::S_PAN: state_in = (depth_ff < amp_pkg::DRY_LIMIT) ? amp_pkg::S_OUT
                                                                   : amp_pkg::S_PAN1;
         amp_pkg::S_PAN1: begin
            state_in = amp_pkg::S_SIN0;
            ret_in   = amp_pkg::S_PAN2;
         end
         amp_pkg::S_PAN2: begin
            state_in = amp_pkg::S_SIN0;
            ret_in   = amp_pkg::S_PAN3;
         end
         amp_pkg::S_PAN3: state_in = amp_pkg::S_PAN4;
         amp_pkg::S_PAN4: state_in = amp_pkg::S_PAN5;
         amp_pkg::S_PAN5: state_in = amp_pkg::S_OUT;
         amp_pkg::S_SIN0: state_in = amp_pkg::S_SIN1;
         amp_pkg::S_SIN1: state_in = amp_pkg::S_SIN2;
         amp_pkg::S_SIN2: state_in = amp_pkg::S_SIN3;
         amp_pkg::S_SIN3: state_in = amp_pkg::S_SIN4;
         amp_pkg::S_SIN4: state_in = ret_ff;
         amp_pkg::S_OUT:  if (out_free) state_in = amp_pkg::S_IDLE;
         default:         state_in = amp_pkg::S_IDLE;
      endcase
   end

   // datapath and multiplier operands
   always_comb begin
      mul_a        = '0;
      mul_b        = '0;
      band_in      = band_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      level_in     = level_ff;
      env_in       = env_ff;
      phase_in     = phase_ff;
      depth_in     = depth_ff;
      num_in       = num_ff;
      t_in         = t_ff;
      sph_in       = sph_ff;
      x_in         = x_ff;
      x2_in        = x2_ff;
      neg_in       = neg_ff;
      sin_in       = sin_ff;
      g_in         = g_ff;
      lfo_in       = lfo_ff;
      ol_in        = ol_ff;
      or_in        = or_ff;
      rsp_l_in     = rsp_l_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_valid_in = rsp_valid_ff && !out_ready;
      case (state_ff)
         amp_pkg::S_IDLE: begin
            if (in_valid) begin
               l_in = in_left;
               r_in = in_right;
            end
         end
         amp_pkg::S_LEV: begin
            mul_a = AW'(diff);
            mul_b = BW'($signed({1'b0, coef}));
         end
         amp_pkg::S_LVL: level_in = SB'(lvl_sum);
         amp_pkg::S_ENV: env_in = env_w[16:0];
         amp_pkg::S_SPD: begin
            mul_a = AW'($signed({1'b0, env_ff}));
            mul_b = BW'($signed({1'b0, cfg.env_speed_mod}));
         end
         amp_pkg::S_INC: begin
            mul_a = AW'($signed({1'b0, cfg.base_increment}));
            mul_b = BW'($signed({1'b0, prod[31:16]}));
         end
         amp_pkg::S_PHS: begin
            phase_in = phase_ff + 32'(cfg.base_increment) + 32'(prod[46:16]);
         end
         amp_pkg::S_DEP: begin
            mul_a = AW'(env_c);
            mul_b = BW'($signed({1'b0, cfg.env_depth_mod}));
         end
         amp_pkg::S_DP2: begin
            mul_a = AW'(dfac);
            mul_b = BW'($signed({1'b0, cfg.pan_depth}));
         end
         amp_pkg::S_DP3: begin
            depth_in = (dp > amp_pkg::ONE_Q16) ? amp_pkg::ONE_Q16 : dp;
            if (cfg.wave_shape < amp_pkg::WAVE_T1) begin
               band_in = amp_pkg::BAND_TRI;
               num_in  = 15'(cfg.wave_shape);
            end else if (cfg.wave_shape < amp_pkg::WAVE_T2) begin
               band_in = amp_pkg::BAND_SKEW;
               num_in  = 15'(cfg.wave_shape - amp_pkg::WAVE_T1);
            end else begin
               band_in = amp_pkg::BAND_SQR;
               num_in  = 15'(cfg.wave_shape - amp_pkg::WAVE_T2);
            end
         end
         // band fraction: reciprocal estimate, then one remainder fix-up
         amp_pkg::S_DIV0: begin
            mul_a = AW'($signed({1'b0, num_ff}));
            mul_b = BW'($signed({1'b0, div_r}));
         end
         amp_pkg::S_DIV1: begin
            t_in  = prod[32:16];
            mul_a = AW'($signed({1'b0, prod[32:16]}));
            mul_b = BW'($signed({1'b0, div_d}));
         end
         amp_pkg::S_DIV2: begin
            if (rem >= 32'(div_d)) t_in = t_ff + 17'd1;
         end
         amp_pkg::S_WT: begin
            if (band_ff == amp_pkg::BAND_SKEW) begin
               mul_a = AW'($signed({1'b0, t_ff}));
               mul_b = BW'($signed({1'b0, amp_pkg::SKEW_GAIN}));
            end else begin
               sph_in = phase_ff;
            end
         end
         amp_pkg::S_SK1: begin
            mul_a = AW'(phc);
            mul_b = BW'($signed({1'b0, prod[31:16]}));
         end
         amp_pkg::S_SK2: sph_in = phase_ff + 32'(p16);
         amp_pkg::S_WB:  lfo_in = 19'(sin_ff);
         amp_pkg::S_WSV: begin
            mul_b = BW'($signed({1'b0, t_ff}));
            if (band_ff == amp_pkg::BAND_TRI) mul_a = AW'(20'(sin_ff) - tri_v);
            else                              mul_a = AW'(tgt - 20'(sin_ff));
         end
         amp_pkg::S_MIXA: lfo_in = 19'(20'(tri_v) + 20'(p16));
         amp_pkg::S_MIXC: lfo_in = 19'(19'(sin_ff) + 19'(p16));
         // soft clip polynomial in Q17
         amp_pkg::S_SC0: begin
            x_in   = mag;
            neg_in = (lfo_ff < 0);
            mul_a  = AW'($signed({1'b0, mag}));
            mul_b  = BW'($signed({1'b0, mag}));
         end
         amp_pkg::S_SC1: begin
            x2_in = prod[33:17];
            mul_a = AW'($signed({1'b0, prod[33:17]}));
            mul_b = BW'($signed({1'b0, amp_pkg::CLIP_C}));
         end
         amp_pkg::S_SC2: begin
            mul_a = AW'($signed({1'b0, x2_ff}));
            mul_b = BW'($signed({1'b0, amp_pkg::CLIP_B - hv}));
         end
         amp_pkg::S_SC3: begin
            mul_a = AW'($signed({1'b0, x2_ff}));
            mul_b = BW'($signed({1'b0, amp_pkg::CLIP_A - hv}));
         end
         amp_pkg::S_SC4: begin
            mul_a = AW'($signed({1'b0, x_ff}));
            mul_b = BW'($signed({1'b0, amp_pkg::CLIP_ONE - hv}));
         end
         amp_pkg::S_SC5: begin
            mul_a = AW'(sc - 20'(lfo_ff));
            mul_b = BW'($signed({1'b0, t_ff}));
         end
         amp_pkg::S_SC6: lfo_in = lfo_ff + 19'(p16);
         amp_pkg::S_PAN: begin
            if (depth_ff < amp_pkg::DRY_LIMIT) begin
               ol_in = l_ff;
               or_in = r_ff;
            end else begin
               mul_a = AW'(lfo_ff);
               mul_b = BW'($signed({1'b0, depth_ff}));
            end
         end
         amp_pkg::S_PAN1: sph_in = 32'({pa, 13'b0});
         amp_pkg::S_PAN2: begin
            g_in   = sin_ff;
            sph_in = sph_ff + amp_pkg::QUARTER_CYCLE;
         end
         amp_pkg::S_PAN3: begin
            mul_a = AW'(l_ff);
            mul_b = BW'(sin_ff);
         end
         amp_pkg::S_PAN4: begin
            ol_in = SB'(p16);
            mul_a = AW'(r_ff);
            mul_b = BW'(g_ff);
         end
         amp_pkg::S_PAN5: or_in = SB'(p16);
         // sine quarter-wave polynomial in Q16
         amp_pkg::S_SIN0: begin
            x_in   = 17'(kq) << (16 - QB);
            neg_in = idx[QB+1];
            mul_a  = AW'($signed({1'b0, 17'(kq) << (16 - QB)}));
            mul_b  = BW'($signed({1'b0, 17'(kq) << (16 - QB)}));
         end
         amp_pkg::S_SIN1: begin
            x2_in = prod[32:16];
            mul_a = AW'($signed({1'b0, prod[32:16]}));
            mul_b = BW'($signed({1'b0, amp_pkg::SIN_C}));
         end
         amp_pkg::S_SIN2: begin
            mul_a = AW'($signed({1'b0, x2_ff}));
            mul_b = BW'($signed({1'b0, amp_pkg::SIN_B - 18'(prod[32:16])}));
         end
         amp_pkg::S_SIN3: begin
            mul_a = AW'($signed({1'b0, x_ff}));
            mul_b = BW'($signed({1'b0, amp_pkg::SIN_A - 18'(prod[32:16])}));
         end
         amp_pkg::S_SIN4: begin
            if (yv > 18'(amp_pkg::ONE_Q16)) sin_in = neg_ff ? -18'sd65536 : 18'sd65536;
            else sin_in = neg_ff ? -$signed(yv) : $signed(yv);
         end
         amp_pkg::S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_l_in     = ol_ff;
               rsp_r_in     = or_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

### sv/envelope_modulated_auto_pan_core.sv
// Top level of the envelope-modulated auto-pan core: config registers and units.
//
// One stereo frame is taken per req beat and gives one rsp beat. All the math
// runs through a single shared 34x19 multiplier stepped by a sequencer. The
// square band adds soft clip when the mix factor is above one half. When the
// depth is below the dry limit the two gain lookups are skipped. A frame
// cannot finish while the previous result still waits in the rsp register.
// req_tready is high only while the block is idle; a finished result sits in
// the rsp register while the next frame is accepted. Config registers are
// written through csr_; the user must write them only while the block is
// idle, as the block itself does not enforce it.
module envelope_modulated_auto_pan_core #(
   parameter int SAMPLE_BITS     = 24,
   parameter int TABLE_ADDR_BITS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // in_left, in_right
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // out_left, out_right
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [30:0]          csr_wdata
);

   localparam int DW = ((2*SAMPLE_BITS+7)/8)*8;

   amp_pkg::cfg_type cfg_ff, cfg_in;

   logic signed [SAMPLE_BITS-1:0] out_l, out_r;
   logic signed [amp_pkg::MUL_A_BITS-1:0] mul_a;
   logic signed [amp_pkg::MUL_B_BITS-1:0] mul_b;
   logic signed [amp_pkg::PROD_BITS-1:0]  prod;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (amp_pkg::reg_index_type'(csr_index))
            amp_pkg::REG_BASE_INC:   cfg_in.base_increment = csr_wdata;
            amp_pkg::REG_WAVE_SHAPE: cfg_in.wave_shape     = csr_wdata[15:0];
            amp_pkg::REG_PAN_DEPTH:  cfg_in.pan_depth      = csr_wdata[15:0];
            amp_pkg::REG_SPEED_MOD:  cfg_in.env_speed_mod  = csr_wdata[15:0];
            amp_pkg::REG_DEPTH_MOD:  cfg_in.env_depth_mod  = csr_wdata[15:0];
            amp_pkg::REG_ATTACK:     cfg_in.attack_coef    = csr_wdata[15:0];
            amp_pkg::REG_RELEASE:    cfg_in.release_coef   = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   amp_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   amp_seq #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_left   ($signed(req_tdata[SAMPLE_BITS-1:0])),
      .in_right  ($signed(req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_left  (out_l),
      .out_right (out_r),
      .mul_a     (mul_a),
      .mul_b     (mul_b),
      .prod      (prod)
   );

   assign rsp_tdata = DW'({out_r, out_l});

endmodule

### sv/amp_chk.sv
// Port-level checks for the auto-pan core, bound to the top level.
module amp_chk #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_tvalid,
   input logic                                    req_tready,
   input logic                                    rsp_tvalid,
   input logic                                    rsp_tready,
   input logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      rsp_tdata
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat dropped or changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high right after an accepted beat");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared one cycle after accept");

endmodule

bind envelope_modulated_auto_pan_core amp_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_amp_chk (.*);

### tb/envelope_modulated_auto_pan_checker.sv
// Checker for the auto-pan core: watches req/rsp/csr, predicts each frame, compares.
module envelope_modulated_auto_pan_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [30:0] csr_wdata,
   output int          mismatches,
   output int          frames_waiting,
   output int          frames_checked
);

   typedef struct {
      logic [23:0] out_left;
      logic [23:0] out_right;
   } pan_frame_type;

   localparam longint MASK32 = 64'hFFFF_FFFF;

   amp_pkg::cfg_type settings;
   longint           env_level;
   longint           lfo_phase;
   pan_frame_type    panned_q[$];

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch @%0t frame %0d: %s got %h want %h", $realtime, frames_checked,
               what, got, want);
      mismatches++;
   endtask

   // quarter-wave polynomial sine, Q16, from a 10-bit address
   function automatic longint sine_at(input longint ph);
      longint idx, quad, r, k, x, x2, t, y;
      idx  = (ph & MASK32) >> 22;
      quad = (idx >> 8) & 3;
      r    = idx & 255;
      k    = (quad & 1) ? 256 - r : r;
      x    = k << 8;
      x2   = (x * x) >> 16;
      t    = 42047 - ((x2 * 4640) >> 16);
      t    = 102944 - ((x2 * t) >> 16);
      y    = (x * t) >> 16;
      if (y > 65536) y = 65536;
      return (quad & 2) ? -y : y;
   endfunction

   function automatic longint soft_clip(input longint v);
      longint m, y2, h, s;
      m  = v < 0 ? -v : v;
      y2 = (m * m) >> 17;
      h  = 17476 - ((y2 * 7074) >> 17);
      h  = 43691 - ((y2 * h) >> 17);
      h  = 131072 - ((y2 * h) >> 17);
      s  = (m * h) >> 17;
      return v < 0 ? -s : s;
   endfunction

   function automatic longint blend(input longint a, input longint b, input longint t);
      return a + (((b - a) * t) >>> 16);
   endfunction

   function automatic longint lfo_value(input longint ph, input longint w);
      longint sv, t, d, k, skew, o;
      sv = sine_at(ph);
      if (w < amp_pkg::WAVE_T1) begin
         d = ph < 64'h8000_0000 ? ph : 64'h1_0000_0000 - ph;
         t = (w * 65536) / amp_pkg::BAND_LOW;
         return blend((d >> 14) - 65536, sv, t);
      end
      if (w < amp_pkg::WAVE_T2) begin
         t    = ((w - amp_pkg::WAVE_T1) * 65536) / amp_pkg::BAND_MID;
         k    = (amp_pkg::SKEW_GAIN * t) >> 16;
         // signed offset from mid-cycle, floored
         skew = ((ph - 64'sh8000_0000) * k) >>> 16;
         return sine_at((ph + skew) & MASK32);
      end
      t = ((w - amp_pkg::WAVE_T2) * 65536) / amp_pkg::BAND_LOW;
      o = blend(sv, sv >= 0 ? 65536 : -65536, t);
      if (t > 32768) o = blend(o, soft_clip(o), t);
      return o;
   endfunction

   function automatic pan_frame_type pan_frame(input logic [47:0] d);
      longint l, r, absl, coef, lv4, env, m, inc, lfo, f, dep, pos, ang, gl, gr;
      pan_frame_type p;
      l    = $signed(d[23:0]);
      r    = $signed(d[47:24]);
      absl = l < 0 ? -l : l;
      coef = absl > env_level ? longint'(settings.attack_coef)
                              : longint'(settings.release_coef);
      env_level += (coef * (absl - env_level)) >>> 16;
      lv4 = env_level * 4;
      if (lv4 > 64'd8388608) lv4 = 64'd8388608;
      env = (lv4 << 16) >> 23;
      m   = (longint'(settings.env_speed_mod) * env) >> 16;
      inc = longint'(settings.base_increment)
            + ((longint'(settings.base_increment) * m) >> 16);
      lfo_phase = (lfo_phase + inc) & MASK32;
      lfo = lfo_value(lfo_phase, longint'(settings.wave_shape));
      f   = (longint'(settings.env_depth_mod) * (env - 32768)) >>> 16;
      dep = (longint'(settings.pan_depth) * (65536 + f)) >>> 16;
      if (dep > 65536) dep = 65536;
      if (dep < amp_pkg::DRY_LIMIT) begin
         p.out_left  = d[23:0];
         p.out_right = d[47:24];
      end else begin
         pos = (lfo * dep) >>> 16;
         ang = ((pos + 65536) << 13) & MASK32;
         gr  = sine_at(ang);
         gl  = sine_at((ang + 64'h4000_0000) & MASK32);
         p.out_left  = 24'((l * gl) >>> 16);
         p.out_right = 24'((r * gr) >>> 16);
      end
      return p;
   endfunction

   assign frames_waiting = panned_q.size();

   always @(posedge clock) begin
      pan_frame_type want;
      if (reset) begin
         settings  <= '0;
         env_level = 0;
         lfo_phase = 0;
         panned_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               amp_pkg::REG_BASE_INC:   settings.base_increment <= csr_wdata;
               amp_pkg::REG_WAVE_SHAPE: settings.wave_shape     <= csr_wdata[15:0];
               amp_pkg::REG_PAN_DEPTH:  settings.pan_depth      <= csr_wdata[15:0];
               amp_pkg::REG_SPEED_MOD:  settings.env_speed_mod  <= csr_wdata[15:0];
               amp_pkg::REG_DEPTH_MOD:  settings.env_depth_mod  <= csr_wdata[15:0];
               amp_pkg::REG_ATTACK:     settings.attack_coef    <= csr_wdata[15:0];
               amp_pkg::REG_RELEASE:    settings.release_coef   <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) panned_q.push_back(pan_frame(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (panned_q.size() == 0) begin
               report("unexpected beat", rsp_tdata, 0);
            end else begin
               want = panned_q.pop_front();
               if (rsp_tdata[23:0] !== want.out_left)
                  report("out_left", rsp_tdata[23:0], want.out_left);
               if (rsp_tdata[47:24] !== want.out_right)
                  report("out_right", rsp_tdata[47:24], want.out_right);
            end
            frames_checked++;
         end
      end
   end

endmodule

### tb/envelope_modulated_auto_pan_core_tb.sv
// Testbench top: clock, reset, frame and register stimulus, verdict.
module envelope_modulated_auto_pan_core_tb;

   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 1000000;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [30:0] csr_wdata = '0;

   int mismatches, frames_waiting, frames_checked;
   int idle_pct, stall_pct;
   int hold_req, hold_seen, hold_cnt;
   int cycles, frames_sent, setting_count;

   envelope_modulated_auto_pan_core u_top (.*);

   envelope_modulated_auto_pan_checker u_chk (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_cnt  <= 1500;
         rsp_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt  <= hold_cnt - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(99) >= stall_pct;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   // called at a falling edge; valid stays high across back-to-back beats
   task automatic send_frame(input logic [23:0] left, input logic [23:0] right);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {right, left};
      do @(posedge clock); while (!req_tready);
      frames_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (frames_waiting != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_settings(input logic [30:0] base, input logic [15:0] shape,
                                input logic [15:0] depth, input logic [15:0] speed,
                                input logic [15:0] dmod, input logic [15:0] att,
                                input logic [15:0] rel);
      drain();
      write_reg(amp_pkg::REG_BASE_INC, base);
      write_reg(amp_pkg::REG_WAVE_SHAPE, {15'($urandom), shape});
      write_reg(amp_pkg::REG_PAN_DEPTH, depth);
      write_reg(amp_pkg::REG_SPEED_MOD, speed);
      write_reg(amp_pkg::REG_DEPTH_MOD, dmod);
      write_reg(amp_pkg::REG_ATTACK, att);
      write_reg(amp_pkg::REG_RELEASE, rel);
      setting_count++;
   endtask

   function automatic logic [23:0] pick_sample();
      case ($urandom_range(5))
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         2: return 24'($signed($urandom_range(4095)) - 2048);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_shape();
      case ($urandom_range(7))
         0: return 16'd0;
         1: return amp_pkg::WAVE_T1 - 16'd1;
         2: return amp_pkg::WAVE_T1;
         3: return amp_pkg::WAVE_T2 - 16'd1;
         4: return amp_pkg::WAVE_T2;
         5: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_q16();
      case ($urandom_range(4))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [23:0] edge_vals [6];
      logic [30:0] base;
      edge_vals = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF, 24'h000001, 24'h400000};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // all-zero registers: depth 0, frames pass through dry
      foreach (edge_vals[i]) send_frame(edge_vals[i], edge_vals[5 - i]);

      // extreme settings, one pass per waveform band
      load_settings(31'h7FFF_FFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
      write_reg(REG_UNUSED, 31'h7FFF_FFFF);
      foreach (edge_vals[i]) send_frame(edge_vals[i], edge_vals[i]);
      load_settings(31'h1234_5678, 16'd30000, 16'hFFFF, 16'd0, 16'd0, 16'h8000, 16'h8000);
      foreach (edge_vals[i]) send_frame(edge_vals[i], edge_vals[(i + 1) % 6]);
      load_settings(31'h0100_0000, 16'hFFFF, 16'd700, 16'h4000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      foreach (edge_vals[i]) send_frame(edge_vals[i], 24'($urandom));

      for (int ph = 0; ph < 12; ph++) begin
         base = ($urandom_range(3) == 0) ? 31'h7FFF_FFFF
                                         : 31'($urandom >> $urandom_range(31));
         load_settings(base, pick_shape(), pick_q16(), pick_q16(), pick_q16(), pick_q16(),
                       pick_q16());
         idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 28 : 81) : 0;
         stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 28 : 81) : 0;
         if (ph == 4) hold_req++;
         repeat (90) send_frame(pick_sample(), pick_sample());
      end

      idle_pct = 0;
      stall_pct = 0;
      req_tvalid <= 1'b0;
      while (frames_waiting != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      $display("%0d frames sent, %0d checked, over %0d register settings", frames_sent,
               frames_checked, setting_count);
      $display("covered all waveform bands, dry pass, stalls and a long receiver hold-off");
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
